// ----- sv/fmpd_pkg.sv -----
// Shared constants, types and the CORDIC angle table of the FM polar discriminator.
package fmpd_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int SAMPLE_WIDTH_DEF  = 18;

  // Samples are pre-scaled so that the product pair fills about 48 bits.
  localparam int GUARD_BASE    = 48;
  localparam int ANGLE_ENTRIES = 24;
  localparam int ANGLE_BITS    = 14;
  localparam int Z_WIDTH       = 18;
  localparam int STEP_WIDTH    = 16;
  localparam int FREQ_WIDTH    = 22;
  localparam int DC_WIDTH      = 16;
  localparam int RATE_WIDTH    = 22;

  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;

  typedef struct packed {
    logic valid;
    logic last;
    logic zero;
  } meta_t;

  // round(atan(2^-k) * 32768 / pi)
  function automatic logic [ANGLE_BITS-1:0] cordic_angle(input int unsigned k);
    logic [ANGLE_BITS-1:0] a;
    unique case (k)
      0:       a = ANGLE_BITS'(8192);
      1:       a = ANGLE_BITS'(4836);
      2:       a = ANGLE_BITS'(2555);
      3:       a = ANGLE_BITS'(1297);
      4:       a = ANGLE_BITS'(651);
      5:       a = ANGLE_BITS'(326);
      6:       a = ANGLE_BITS'(163);
      7:       a = ANGLE_BITS'(81);
      8:       a = ANGLE_BITS'(41);
      9:       a = ANGLE_BITS'(20);
      10:      a = ANGLE_BITS'(10);
      11:      a = ANGLE_BITS'(5);
      12:      a = ANGLE_BITS'(3);
      13:      a = ANGLE_BITS'(1);
      14:      a = ANGLE_BITS'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- sv/fmpd_ifs.sv -----
// Valid/ready channel interfaces for IQ samples and discriminator results.
interface fmpd_sample_if #(
  parameter int SAMPLE_WIDTH = fmpd_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_phase;
  logic signed [SAMPLE_WIDTH-1:0] quadrature;
  logic                           last_sample;

  modport source (output valid, in_phase, quadrature, last_sample, input ready);
  modport sink   (input valid, in_phase, quadrature, last_sample, output ready);
endinterface

interface fmpd_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [fmpd_pkg::STEP_WIDTH-1:0] phase_step;
  logic signed [fmpd_pkg::FREQ_WIDTH-1:0] frequency_hz;
  logic                                   last_result;

  modport source (output valid, phase_step, frequency_hz, last_result, input ready);
  modport sink   (input valid, phase_step, frequency_hz, last_result, output ready);
endinterface

// ----- sv/fmpd_apb_regs.sv -----
// APB configuration registers: DC offset and sample rate.
module fmpd_apb_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fmpd_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [fmpd_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [fmpd_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready,
  output logic [fmpd_pkg::DC_WIDTH-1:0]       dc_offset,
  output logic [fmpd_pkg::RATE_WIDTH-1:0]     rate_hz
);
  import fmpd_pkg::*;

  localparam logic REG_DC_OFFSET = 1'b0;
  localparam logic REG_RATE_HZ   = 1'b1;

  localparam logic [DC_WIDTH-1:0]   DC_OFFSET_RESET = DC_WIDTH'(32640);
  localparam logic [RATE_WIDTH-1:0] RATE_HZ_RESET   = RATE_WIDTH'(256000);

  logic reg_index;
  logic wr_en;

  // word address; byte lanes ignored
  assign reg_index = paddr[2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_offset <= DC_OFFSET_RESET;
      rate_hz   <= RATE_HZ_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_DC_OFFSET: dc_offset <= pwdata[DC_WIDTH-1:0];
        REG_RATE_HZ:   rate_hz   <= pwdata[RATE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_DC_OFFSET: prdata = APB_DATA_WIDTH'(dc_offset);
      REG_RATE_HZ:   prdata = APB_DATA_WIDTH'(rate_hz);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- sv/fmpd_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation cell with its output register.
module fmpd_cordic_cell #(
  parameter int XW    = 54,
  parameter int STAGE = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  fmpd_pkg::meta_t                     meta_in,
  input  logic signed [XW-1:0]                x_in,
  input  logic signed [XW-1:0]                y_in,
  input  logic signed [fmpd_pkg::Z_WIDTH-1:0] z_in,
  output fmpd_pkg::meta_t                     meta_out,
  output logic signed [XW-1:0]                x_out,
  output logic signed [XW-1:0]                y_out,
  output logic signed [fmpd_pkg::Z_WIDTH-1:0] z_out
);
  import fmpd_pkg::*;

  localparam logic signed [Z_WIDTH-1:0] ANG = Z_WIDTH'(cordic_angle(STAGE));

  logic signed [XW-1:0]      dx;
  logic signed [XW-1:0]      dy;
  logic signed [XW-1:0]      x_next;
  logic signed [XW-1:0]      y_next;
  logic signed [Z_WIDTH-1:0] z_next;

  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  // rotate toward y = 0
  always_comb begin
    if (!y_in[XW-1]) begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + ANG;
    end else begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_out.valid <= 1'b0;
    end else if (en) begin
      meta_out <= meta_in;
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
    end
  end

endmodule

// ----- sv/fmpd_freq_scale.sv -----
// Angle saturation, phase-step to Hz scaling with rounding, and the output register.
module fmpd_freq_scale (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  fmpd_pkg::meta_t                        meta_in,
  input  logic signed [fmpd_pkg::Z_WIDTH-1:0]    z_in,
  input  logic [fmpd_pkg::RATE_WIDTH-1:0]        rate_hz,
  output logic                                   out_valid,
  output logic signed [fmpd_pkg::STEP_WIDTH-1:0] phase_step,
  output logic signed [fmpd_pkg::FREQ_WIDTH-1:0] frequency_hz,
  output logic                                   last_result
);
  import fmpd_pkg::*;

  localparam int PW          = STEP_WIDTH + RATE_WIDTH + 1;
  localparam int SCALE_SHIFT = 16;
  localparam int RNDW        = PW - SCALE_SHIFT;

  localparam logic signed [Z_WIDTH-1:0] Z_MAX = Z_WIDTH'((1 << (STEP_WIDTH-1)) - 1);
  localparam logic signed [Z_WIDTH-1:0] Z_MIN = Z_WIDTH'(-(1 << (STEP_WIDTH-1)));
  localparam logic [PW-1:0]   HALF    = PW'(1 << (SCALE_SHIFT-1));
  localparam logic [RNDW-1:0] LIM_POS = RNDW'((1 << (FREQ_WIDTH-1)) - 1);
  localparam logic [RNDW-1:0] LIM_NEG = RNDW'(1 << (FREQ_WIDTH-1));
  localparam logic signed [FREQ_WIDTH-1:0] F_MAX = FREQ_WIDTH'((1 << (FREQ_WIDTH-1)) - 1);
  localparam logic signed [FREQ_WIDTH-1:0] F_MIN = FREQ_WIDTH'(-(1 << (FREQ_WIDTH-1)));

  logic signed [STEP_WIDTH-1:0] step_sat;

  logic                         a_valid;
  logic                         a_last;
  logic signed [STEP_WIDTH-1:0] a_step;
  logic signed [PW-1:0]         a_prod;

  logic [PW-1:0]                a_mag;

  logic                         b_valid;
  logic                         b_last;
  logic signed [STEP_WIDTH-1:0] b_step;
  logic                         b_neg;
  logic [RNDW-1:0]              b_rnd;

  logic signed [FREQ_WIDTH-1:0] f_next;

  // atan2(0,0) reads as zero; +pi and beyond saturate
  always_comb begin
    priority if (meta_in.zero) begin
      step_sat = '0;
    end else if (z_in > Z_MAX) begin
      step_sat = Z_MAX[STEP_WIDTH-1:0];
    end else if (z_in < Z_MIN) begin
      step_sat = Z_MIN[STEP_WIDTH-1:0];
    end else begin
      step_sat = z_in[STEP_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= meta_in.valid;
      a_last  <= meta_in.last;
      a_step  <= step_sat;
      a_prod  <= step_sat * $signed({1'b0, rate_hz});
    end
  end

  assign a_mag = a_prod[PW-1] ? PW'(-a_prod) : PW'(a_prod);

  // round half away from zero on the magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
      b_last  <= a_last;
      b_step  <= a_step;
      b_neg   <= a_prod[PW-1];
      b_rnd   <= RNDW'((a_mag + HALF) >> SCALE_SHIFT);
    end
  end

  always_comb begin
    if (b_neg) begin
      f_next = (b_rnd >= LIM_NEG) ? F_MIN : -$signed(FREQ_WIDTH'(b_rnd));
    end else begin
      f_next = (b_rnd > LIM_POS) ? F_MAX : $signed(FREQ_WIDTH'(b_rnd));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid    <= b_valid;
      last_result  <= b_last;
      phase_step   <= b_step;
      frequency_hz <= f_next;
    end
  end

endmodule

// ----- sv/fm_polar_discriminator.sv -----
// Top level of the FM polar discriminator: offset removal, conjugate product, CORDIC chain.
//
// Usage:
//   samples  (sink): one IQ sample per transaction, signed Q10.8 in_phase and
//                    quadrature plus a last_sample flag.
//   results  (source): phase_step in units of pi/32768, frequency_hz rounded,
//                    and last_result copied from the sample that made it.
//   APB port: register 0 at byte 0 is dc_offset (unsigned Q8.8), register 1
//             at byte 4 is the IQ sample rate in Hz. Write only while idle.
// The first sample of a stream, and the first after a last_sample, only
// primes the held pair and yields no result transaction.
// From sample to result the registers are offset removal, products, sum,
// pre-rotation, one register per CORDIC cell, then saturation and multiply,
// rounding, and the output register.
// Throughput: one sample per cycle while no result is stalled. Every stage
// is a register that moves on a common advance enable; the 22 x 16 scaling
// multiplier and the cell chain are fully pipelined.
// A stalled result (valid high, ready low) freezes the whole pipeline and
// drops samples.ready in the same cycle; nothing is lost.
// Reset clears all valid bits, forgets the held pair and restores the
// register defaults (127.5 offset, 256000 Hz).
module fm_polar_discriminator #(
  parameter int CORDIC_STAGES = fmpd_pkg::CORDIC_STAGES_DEF,
  parameter int SAMPLE_WIDTH  = fmpd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  fmpd_sample_if.sink                         samples,
  fmpd_result_if.source                       results,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fmpd_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [fmpd_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [fmpd_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready
);
  import fmpd_pkg::*;

  // corrected sample width: holds sample minus a 16-bit offset exactly
  localparam int CIW   = ((SAMPLE_WIDTH > DC_WIDTH + 1) ? SAMPLE_WIDTH : DC_WIDTH + 1) + 1;
  localparam int PRODW = 2 * CIW;
  localparam int RW    = PRODW + 1;
  localparam int GUARD = GUARD_BASE - 2 * SAMPLE_WIDTH;
  // CORDIC gain and the pre-rotation negate need headroom
  localparam int XW    = RW + GUARD + 3;

  localparam logic signed [Z_WIDTH-1:0] Z_PI_POS = Z_WIDTH'(1 << (STEP_WIDTH-1));
  localparam logic signed [Z_WIDTH-1:0] Z_PI_NEG = Z_WIDTH'(-(1 << (STEP_WIDTH-1)));

  logic [DC_WIDTH-1:0]   dc_offset;
  logic [RATE_WIDTH-1:0] rate_hz;

  logic adv;
  logic acc;

  // held pair from the previous sample
  logic signed [CIW-1:0] prev_i;
  logic signed [CIW-1:0] prev_q;
  logic                  have_previous;

  logic signed [CIW-1:0] ci_next;
  logic signed [CIW-1:0] cq_next;

  // stage 1: corrected new pair with the held pair
  logic                  p1_valid;
  logic                  p1_last;
  logic signed [CIW-1:0] p1_ci;
  logic signed [CIW-1:0] p1_cq;
  logic signed [CIW-1:0] p1_pi;
  logic signed [CIW-1:0] p1_pq;

  // stage 2: partial products
  logic                    p2_valid;
  logic                    p2_last;
  logic signed [PRODW-1:0] p2_ii;
  logic signed [PRODW-1:0] p2_qq;
  logic signed [PRODW-1:0] p2_iq;
  logic signed [PRODW-1:0] p2_qi;

  // stage 3: conjugate product re + j*im
  logic                 p3_valid;
  logic                 p3_last;
  logic signed [RW-1:0] p3_re;
  logic signed [RW-1:0] p3_im;

  logic signed [XW-1:0]      re_ext;
  logic signed [XW-1:0]      im_ext;
  logic signed [XW-1:0]      re_sc;
  logic signed [XW-1:0]      im_sc;
  logic                      re_neg;
  logic signed [Z_WIDTH-1:0] z_init;

  // cell chain nodes; node 0 is the pre-rotation register
  meta_t                     m_c [CORDIC_STAGES+1];
  logic signed [XW-1:0]      x_c [CORDIC_STAGES+1];
  logic signed [XW-1:0]      y_c [CORDIC_STAGES+1];
  logic signed [Z_WIDTH-1:0] z_c [CORDIC_STAGES+1];

  fmpd_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .dc_offset (dc_offset),
    .rate_hz   (rate_hz)
  );

  // whole pipeline moves when the output slot is empty or being drained
  assign adv           = !results.valid || results.ready;
  assign samples.ready = adv && !rst;
  assign acc           = samples.valid && samples.ready;

  assign ci_next = CIW'(samples.in_phase)   - CIW'($signed({1'b0, dc_offset}));
  assign cq_next = CIW'(samples.quadrature) - CIW'($signed({1'b0, dc_offset}));

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
    end else if (acc) begin
      prev_i        <= ci_next;
      prev_q        <= cq_next;
      // a last sample ends the stream; the next one only primes
      have_previous <= !samples.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= acc && have_previous;
      p1_last  <= samples.last_sample;
      p1_ci    <= ci_next;
      p1_cq    <= cq_next;
      p1_pi    <= prev_i;
      p1_pq    <= prev_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (adv) begin
      p2_valid <= p1_valid;
      p2_last  <= p1_last;
      p2_ii    <= p1_pi * p1_ci;
      p2_qq    <= p1_pq * p1_cq;
      p2_iq    <= p1_ci * p1_pq;
      p2_qi    <= p1_pi * p1_cq;
    end
  end

  // re = Ip*In + Qp*Qn, im = In*Qp - Ip*Qn
  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (adv) begin
      p3_valid <= p2_valid;
      p3_last  <= p2_last;
      p3_re    <= RW'(p2_ii) + RW'(p2_qq);
      p3_im    <= RW'(p2_iq) - RW'(p2_qi);
    end
  end

  // pre-rotation: fold the left half plane onto the right, start at +/-pi
  assign re_ext = XW'(p3_re);
  assign im_ext = XW'(p3_im);
  assign re_sc  = re_ext <<< GUARD;
  assign im_sc  = im_ext <<< GUARD;
  assign re_neg = p3_re[RW-1];

  always_comb begin
    if (!re_neg) begin
      z_init = '0;
    end else if (!p3_im[RW-1]) begin
      z_init = Z_PI_POS;
    end else begin
      z_init = Z_PI_NEG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_c[0].valid <= 1'b0;
    end else if (adv) begin
      m_c[0].valid <= p3_valid;
      m_c[0].last  <= p3_last;
      m_c[0].zero  <= (p3_re == '0) && (p3_im == '0);
      x_c[0]       <= re_neg ? -re_sc : re_sc;
      y_c[0]       <= re_neg ? -im_sc : im_sc;
      z_c[0]       <= z_init;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    fmpd_cordic_cell #(
      .XW    (XW),
      .STAGE (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .meta_in  (m_c[k]),
      .x_in     (x_c[k]),
      .y_in     (y_c[k]),
      .z_in     (z_c[k]),
      .meta_out (m_c[k+1]),
      .x_out    (x_c[k+1]),
      .y_out    (y_c[k+1]),
      .z_out    (z_c[k+1])
    );
  end

  fmpd_freq_scale u_freq (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .meta_in      (m_c[CORDIC_STAGES]),
    .z_in         (z_c[CORDIC_STAGES]),
    .rate_hz      (rate_hz),
    .out_valid    (results.valid),
    .phase_step   (results.phase_step),
    .frequency_hz (results.frequency_hz),
    .last_result  (results.last_result)
  );

  // end of stream forgets the held pair
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (acc && samples.last_sample) |=> !have_previous)
    else $error("held pair survived a last sample");

  // no phase step means no frequency
  a_zero_step: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.phase_step == '0) |-> (results.frequency_hz == '0))
    else $error("nonzero frequency for zero phase step");

  // frequency follows the sign of the phase step
  a_sign_pos: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.phase_step[STEP_WIDTH-1])
      |-> !results.frequency_hz[FREQ_WIDTH-1])
    else $error("negative frequency for positive phase step");

  a_sign_neg: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.phase_step[STEP_WIDTH-1])
      |-> (results.frequency_hz[FREQ_WIDTH-1] || results.frequency_hz == '0))
    else $error("positive frequency for negative phase step");

endmodule

// ----- tb/sv/tb_fm_polar_discriminator.sv -----
// Self-checking testbench for the FM polar discriminator with its own CORDIC predictor.
`timescale 1ns / 1ps

module tb_fm_polar_discriminator;
  import fmpd_pkg::*;

  localparam int SW         = SAMPLE_WIDTH_DEF;
  localparam int STAGES     = CORDIC_STAGES_DEF;
  localparam int SAMPLE_MIN = -(1 << (SW - 1));
  localparam int SAMPLE_MAX = (1 << (SW - 1)) - 1;
  // Product pair is scaled up so that it fills about 48 bits before the CORDIC.
  localparam int GUARD      = GUARD_BASE - 2 * SW;

  localparam logic [DC_WIDTH-1:0]   DC_OFFSET_RESET = 16'd32640;
  localparam logic [RATE_WIDTH-1:0] RATE_HZ_RESET   = 22'd256000;

  // Register map: one register per 32-bit word.
  localparam logic [APB_ADDR_WIDTH-1:0] ADDR_DC_OFFSET = 3'd0;
  localparam logic [APB_ADDR_WIDTH-1:0] ADDR_RATE_HZ   = 3'd4;

  // Pipeline is CORDIC_STAGES + 7 deep; leave plenty of margin for draining.
  localparam int DRAIN_CYCLES = 2 * (STAGES + 7);
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 600000;

  // round(atan(2^-k) * 32768 / pi), own copy for the predictor.
  localparam int ATAN_STEP [ANGLE_ENTRIES] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
    3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [SW-1:0] in_phase;
    logic signed [SW-1:0] quadrature;
    logic                 last;
  } iq_sample_t;

  typedef struct packed {
    logic signed [STEP_WIDTH-1:0] step;
    logic signed [FREQ_WIDTH-1:0] freq;
    logic                         last;
  } demod_t;

  logic clk;
  logic rst;

  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  fmpd_sample_if #(.SAMPLE_WIDTH(SW)) smp ();
  fmpd_result_if                      res ();

  fm_polar_discriminator #(
    .CORDIC_STAGES(STAGES),
    .SAMPLE_WIDTH (SW)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(smp),
    .results(res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Stimulus and scoreboard state
  iq_sample_t pending_samples[$];
  demod_t     expected_demod[$];
  int         samples_queued   = 0;
  int         samples_accepted = 0;
  int         mismatches       = 0;
  int         cycles           = 0;

  // Idle percentages per side, changed between phases.
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  // Long receiver hold-off: requested once by the stimulus, timed by the receiver.
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_count = 0;

  // Predictor copy of the registers and the held pair
  logic [DC_WIDTH-1:0]   dc_offset_cfg = DC_OFFSET_RESET;
  logic [RATE_WIDTH-1:0] rate_hz_cfg   = RATE_HZ_RESET;
  longint                held_i     = 0;
  longint                held_q     = 0;
  logic                  held_valid = 1'b0;

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // Vectoring CORDIC: angle of (re, im) in pi/32768 units, saturated to 16 bits.
  function automatic int cordic_phase(longint re, longint im);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    if (re == 0 && im == 0) begin
      return 0;
    end
    x = re <<< GUARD;
    y = im <<< GUARD;
    z = 0;
    // Left half plane: fold onto the right half and start from +/- pi.
    if (x < 0) begin
      z = (y >= 0) ? 64'sd32768 : -64'sd32768;
      x = -x;
      y = -y;
    end
    for (int k = 0; k < STAGES && k < ANGLE_ENTRIES; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_STEP[k];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_STEP[k];
      end
    end
    if (z > 32767) z = 32767;
    if (z < -32768) z = -32768;
    return int'(z);
  endfunction

  // Runs one accepted sample through the discriminator, queues any result.
  function automatic void demodulate_sample(iq_sample_t s);
    longint ci;
    longint cq;
    longint re;
    longint im;
    longint p;
    longint mag;
    longint f;
    int     step;
    demod_t r;
    ci = longint'(s.in_phase) - longint'(dc_offset_cfg);
    cq = longint'(s.quadrature) - longint'(dc_offset_cfg);
    if (held_valid) begin
      // Conjugate product: previous * conj(new)
      re   = held_i * ci + held_q * cq;
      im   = ci * held_q - held_i * cq;
      step = cordic_phase(re, im);
      p    = longint'(step) * longint'(rate_hz_cfg);
      mag  = (p < 0) ? -p : p;
      f    = (mag + 32768) >>> 16;  // round half away from zero
      if (p < 0) f = -f;
      if (f > 2097151) f = 2097151;
      if (f < -2097152) f = -2097152;
      r.step = step[STEP_WIDTH-1:0];
      r.freq = f[FREQ_WIDTH-1:0];
      r.last = s.last;
      expected_demod.push_back(r);
    end
    held_i     = ci;
    held_q     = cq;
    held_valid = !s.last;  // a last sample ends the stream
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  function automatic void queue_sample(int i, int q, bit last);
    iq_sample_t s;
    if (i < SAMPLE_MIN) i = SAMPLE_MIN;
    if (i > SAMPLE_MAX) i = SAMPLE_MAX;
    if (q < SAMPLE_MIN) q = SAMPLE_MIN;
    if (q > SAMPLE_MAX) q = SAMPLE_MAX;
    s.in_phase   = SW'(i);
    s.quadrature = SW'(q);
    s.last       = last;
    pending_samples.push_back(s);
    samples_queued++;
  endfunction

  // Random streams, mostly rotating phasors around the DC offset, each closed
  // by a last sample; the rest is raw noise, corner values and broken streams.
  task automatic queue_random(input int count);
    int  target;
    int  len;
    int  kind;
    int  dc;
    int  raw_i;
    int  raw_q;
    bit  last;
    real amp;
    real ph;
    real dph;
    int  corner[4];
    target = samples_queued + count;
    while (samples_queued < target) begin
      len    = $urandom_range(1, 60);
      kind   = $urandom_range(0, 9);
      dc     = int'(dc_offset_cfg);
      corner = '{SAMPLE_MIN, SAMPLE_MAX, 0, dc};
      amp    = real'($urandom_range(0, 1 << $urandom_range(0, SW - 1)));
      ph     = real'($urandom_range(0, 6283)) / 1000.0;
      dph    = real'($urandom_range(0, 6283)) / 1000.0 - 3.1415;
      for (int n = 0; n < len; n++) begin
        last = (n == len - 1);
        if (kind <= 6) begin
          raw_i = dc + int'(amp * $cos(ph));
          raw_q = dc + int'(amp * $sin(ph));
          ph    = ph + dph;
        end else if (kind == 8) begin
          raw_i = corner[$urandom_range(0, 3)];
          raw_q = corner[$urandom_range(0, 3)];
        end else begin
          raw_i = int'($urandom_range(0, 2 * SAMPLE_MAX + 1)) + SAMPLE_MIN;
          raw_q = int'($urandom_range(0, 2 * SAMPLE_MAX + 1)) + SAMPLE_MIN;
          if (kind == 9) last = ($urandom_range(0, 7) == 0);
        end
        queue_sample(raw_i, raw_q, last);
      end
    end
  endtask

  // Waits until every sample went in and every result came out, then lets
  // the pipeline run empty (samples that make no result may still be inside).
  task automatic wait_drained();
    while (samples_accepted != samples_queued || expected_demod.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, access cycle; register takes the data at the access edge.
  task automatic apb_write(input logic [APB_ADDR_WIDTH-1:0] addr,
                           input logic [APB_DATA_WIDTH-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Upper bits beyond the register width are dropped.
    case (addr)
      ADDR_DC_OFFSET: dc_offset_cfg = data[DC_WIDTH-1:0];
      ADDR_RATE_HZ:   rate_hz_cfg   = data[RATE_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Clock
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Sample driver: pulls from the pending queue, random gaps between items
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : drive_samples
    iq_sample_t nxt;
    if (rst) begin
      smp.valid <= 1'b0;
    end else if (!smp.valid || smp.ready) begin
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        nxt = pending_samples.pop_front();
        smp.valid       <= 1'b1;
        smp.in_phase    <= nxt.in_phase;
        smp.quadrature  <= nxt.quadrature;
        smp.last_sample <= nxt.last;
      end else begin
        smp.valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result receiver: random back-pressure plus one long hold-off
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      // Pipeline fills up and must push back on the sample side.
      res.ready  <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == LONG_HOLD - 1) hold_done <= 1'b1;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: predicts on each sample transaction, checks each result transaction
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    iq_sample_t s;
    demod_t     want;
    if (!rst) begin
      if (smp.valid && smp.ready) begin
        s.in_phase   = smp.in_phase;
        s.quadrature = smp.quadrature;
        s.last       = smp.last_sample;
        demodulate_sample(s);
        samples_accepted++;
      end
      if (res.valid && res.ready) begin
        if (expected_demod.size() == 0) begin
          $display("%0t: unexpected result: step %0d freq %0d last %0b", $time,
                   res.phase_step, res.frequency_hz, res.last_result);
          mismatches++;
        end else begin
          want = expected_demod.pop_front();
          if (res.phase_step !== want.step || res.frequency_hz !== want.freq ||
              res.last_result !== want.last) begin
            $display("%0t: expected step %0d freq %0d last %0b, got step %0d freq %0d last %0b",
                     $time, want.step, want.freq, want.last,
                     res.phase_step, res.frequency_hz, res.last_result);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin : run_phases
    int d;
    // Known values on every input before the first edge
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    smp.valid       = 1'b0;
    smp.in_phase    = '0;
    smp.quadrature  = '0;
    smp.last_sample = 1'b0;
    res.ready       = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase 1: reset defaults, slow receiver
    src_idle_pct = 9;
    snk_idle_pct = 86;
    d = int'(dc_offset_cfg);
    queue_sample(d + 1000, d, 0);          // primes the pair, no result
    queue_sample(d, d + 1000, 0);          // quarter turn
    queue_sample(d - 1000, d, 0);
    queue_sample(d + 1000, d, 0);          // half turn, saturates at +pi
    queue_sample(d, d, 0);                 // zero vector: atan2(0,0)
    queue_sample(d, d, 0);
    queue_sample(SAMPLE_MAX, SAMPLE_MAX, 0);
    queue_sample(SAMPLE_MIN, SAMPLE_MIN, 0); // opposite vector, +pi again
    queue_sample(SAMPLE_MAX, SAMPLE_MIN, 0);
    queue_sample(SAMPLE_MIN, SAMPLE_MAX, 1); // end of stream
    queue_sample(5, -7, 0);                // new stream, no result
    queue_sample(-1, 0, 1);
    queue_sample(0, 0, 1);                 // single sample stream, no result
    queue_sample(SAMPLE_MAX, 0, 0);
    queue_sample(0, SAMPLE_MIN, 0);
    queue_sample(d + 1000, d, 0);
    queue_sample(d - 1000, d + 1, 0);      // left half plane, below the axis
    queue_sample(d + 1, d - 1000, 1);
    queue_random(500);
    wait_drained();

    // Phase 2: zero offset, top sample rate, bursty sender
    apb_write(ADDR_DC_OFFSET, 32'h0000_0000);
    apb_write(ADDR_RATE_HZ, 32'h003F_FFFF);
    src_idle_pct = 86;
    snk_idle_pct = 9;
    queue_sample(0, 0, 0);
    queue_sample(0, 0, 0);
    queue_sample(SAMPLE_MAX, 0, 0);
    queue_sample(SAMPLE_MIN, 0, 1);
    queue_random(450);
    wait_drained();

    // Phase 3: full offset, 1 Hz rate, no idling, one long receiver stall
    apb_write(ADDR_DC_OFFSET, 32'h0000_FFFF);
    apb_write(ADDR_RATE_HZ, 32'h0000_0001);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    queue_random(400);
    hold_req = 1'b1;
    wait_drained();

    // Phase 4: random offset, rate masked down to zero (frequency always 0)
    apb_write(ADDR_DC_OFFSET, {16'($urandom()), 16'($urandom())});
    apb_write(ADDR_RATE_HZ, 32'hFFC0_0000);
    queue_random(400);
    wait_drained();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/fmpd_pkg.sv
sv/fmpd_ifs.sv
sv/fmpd_apb_regs.sv
sv/fmpd_cordic_cell.sv
sv/fmpd_freq_scale.sv
sv/fm_polar_discriminator.sv
tb/sv/tb_fm_polar_discriminator.sv
